>>> hdl/cmfs_pkg.sv
`timescale 1ns / 1ps

package cmfs_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int FACE_W         = 3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              neg_s;
    logic              neg_t;
    logic              zero;
  } side_t;

endpackage

>>> hdl/cmfs_if.sv
`timescale 1ns / 1ps

interface cmfs_in_if #(
  parameter int COMP_WIDTH = cmfs_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] dir_x;
  logic signed [COMP_WIDTH-1:0] dir_y;
  logic signed [COMP_WIDTH-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfs_out_if #(
  parameter int COMP_WIDTH = cmfs_pkg::COMP_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [cmfs_pkg::FACE_W-1:0]   face_index;
  logic signed [COMP_WIDTH-1:0]  coord_s;
  logic signed [COMP_WIDTH-1:0]  coord_t;
  logic                          zero_vector;

  modport source (output valid, output face_index, output coord_s, output coord_t,
                  output zero_vector, input ready);
  modport sink   (input valid, input face_index, input coord_s, input coord_t,
                  input zero_vector, output ready);
endinterface

>>> hdl/cmfs_select.sv
`timescale 1ns / 1ps

module cmfs_select #(
  parameter int COMP_WIDTH = cmfs_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = cmfs_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  cmfs_in_if.sink                            in_ch,
  output logic                               o_vld,
  input  logic                               o_rdy,
  output cmfs_pkg::side_t                    o_side,
  output logic [COMP_WIDTH-1:0]              o_den,
  output logic [COMP_WIDTH+FRAC_BITS+1:0]    o_rem_s,
  output logic [COMP_WIDTH+FRAC_BITS+1:0]    o_rem_t
);

  localparam int W  = COMP_WIDTH;
  localparam int NW = COMP_WIDTH + FRAC_BITS + 2;

  logic [W-1:0]    mag_x, mag_y, mag_z;
  logic [W-1:0]    num_s, num_t, den;
  logic            neg_s, neg_t, neg_a, zero;
  cmfs_pkg::axis_t axis;
  cmfs_pkg::side_t side_nxt;

  logic            vld_r;
  cmfs_pkg::side_t side_r;
  logic [W-1:0]    den_r;
  logic [NW-1:0]   rem_s_r, rem_t_r;

  assign mag_x = in_ch.dir_x[W-1] ? $unsigned(-in_ch.dir_x) : $unsigned(in_ch.dir_x);
  assign mag_y = in_ch.dir_y[W-1] ? $unsigned(-in_ch.dir_y) : $unsigned(in_ch.dir_y);
  assign mag_z = in_ch.dir_z[W-1] ? $unsigned(-in_ch.dir_z) : $unsigned(in_ch.dir_z);

  assign zero = (mag_x == '0) && (mag_y == '0) && (mag_z == '0);

  always_comb begin
    if (mag_x >= mag_y && mag_x >= mag_z) begin
      axis = cmfs_pkg::AXIS_X;
    end else if (mag_y >= mag_z) begin
      axis = cmfs_pkg::AXIS_Y;
    end else begin
      axis = cmfs_pkg::AXIS_Z;
    end
    case (axis)
      cmfs_pkg::AXIS_Y: begin
        den   = mag_y;
        neg_a = in_ch.dir_y[W-1];
        num_s = mag_z;
        neg_s = in_ch.dir_z[W-1];
        num_t = mag_x;
        neg_t = in_ch.dir_x[W-1];
      end
      cmfs_pkg::AXIS_Z: begin
        den   = mag_z;
        neg_a = in_ch.dir_z[W-1];
        num_s = mag_x;
        neg_s = in_ch.dir_x[W-1];
        num_t = mag_y;
        neg_t = in_ch.dir_y[W-1];
      end
      default: begin
        den   = mag_x;
        neg_a = in_ch.dir_x[W-1];
        num_s = mag_y;
        neg_s = in_ch.dir_y[W-1];
        num_t = mag_z;
        neg_t = in_ch.dir_z[W-1];
      end
    endcase
    side_nxt.face  = zero ? '0 : {axis, neg_a};
    side_nxt.neg_s = neg_s;
    side_nxt.neg_t = neg_t;
    side_nxt.zero  = zero;
  end

  assign in_ch.ready = !vld_r || o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  // numerator of the rounded quotient: 2*num*2^F + den
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      side_r  <= side_nxt;
      den_r   <= den;
      rem_s_r <= (NW'(num_s) << (FRAC_BITS + 1)) + NW'(den);
      rem_t_r <= (NW'(num_t) << (FRAC_BITS + 1)) + NW'(den);
    end
  end

  assign o_vld   = vld_r;
  assign o_side  = side_r;
  assign o_den   = den_r;
  assign o_rem_s = rem_s_r;
  assign o_rem_t = rem_t_r;

endmodule

>>> hdl/cmfs_div_cell.sv
`timescale 1ns / 1ps

module cmfs_div_cell #(
  parameter int COMP_WIDTH = cmfs_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = cmfs_pkg::FRAC_BITS_DEF,
  parameter int SH         = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               i_vld,
  output logic                               i_rdy,
  input  cmfs_pkg::side_t                    i_side,
  input  logic [COMP_WIDTH-1:0]              i_den,
  input  logic [COMP_WIDTH+FRAC_BITS+1:0]    i_rem_s,
  input  logic [COMP_WIDTH+FRAC_BITS+1:0]    i_rem_t,
  input  logic [FRAC_BITS:0]                 i_q_s,
  input  logic [FRAC_BITS:0]                 i_q_t,
  output logic                               o_vld,
  input  logic                               o_rdy,
  output cmfs_pkg::side_t                    o_side,
  output logic [COMP_WIDTH-1:0]              o_den,
  output logic [COMP_WIDTH+FRAC_BITS+1:0]    o_rem_s,
  output logic [COMP_WIDTH+FRAC_BITS+1:0]    o_rem_t,
  output logic [FRAC_BITS:0]                 o_q_s,
  output logic [FRAC_BITS:0]                 o_q_t
);

  localparam int W  = COMP_WIDTH;
  localparam int NW = COMP_WIDTH + FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;

  logic [NW-1:0]   trial;
  logic            ge_s, ge_t;
  logic [NW-1:0]   rem_s_nxt, rem_t_nxt;
  logic [QW-1:0]   q_s_nxt, q_t_nxt;

  logic            vld_r;
  cmfs_pkg::side_t side_r;
  logic [W-1:0]    den_r;
  logic [NW-1:0]   rem_s_r, rem_t_r;
  logic [QW-1:0]   q_s_r, q_t_r;

  // trial subtract of 2*den weighted by this cell's quotient bit
  assign trial     = NW'({i_den, 1'b0}) << SH;
  assign ge_s      = i_rem_s >= trial;
  assign ge_t      = i_rem_t >= trial;
  assign rem_s_nxt = ge_s ? i_rem_s - trial : i_rem_s;
  assign rem_t_nxt = ge_t ? i_rem_t - trial : i_rem_t;
  assign q_s_nxt   = i_q_s | (ge_s ? (QW'(1) << SH) : '0);
  assign q_t_nxt   = i_q_t | (ge_t ? (QW'(1) << SH) : '0);

  assign i_rdy = !vld_r || o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_vld && i_rdy) begin
      side_r  <= i_side;
      den_r   <= i_den;
      rem_s_r <= rem_s_nxt;
      rem_t_r <= rem_t_nxt;
      q_s_r   <= q_s_nxt;
      q_t_r   <= q_t_nxt;
    end
  end

  assign o_vld   = vld_r;
  assign o_side  = side_r;
  assign o_den   = den_r;
  assign o_rem_s = rem_s_r;
  assign o_rem_t = rem_t_r;
  assign o_q_s   = q_s_r;
  assign o_q_t   = q_t_r;

endmodule

>>> hdl/cmfs_out_stage.sv
`timescale 1ns / 1ps

module cmfs_out_stage #(
  parameter int COMP_WIDTH = cmfs_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = cmfs_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  i_vld,
  output logic                  i_rdy,
  input  cmfs_pkg::side_t       i_side,
  input  logic [FRAC_BITS:0]    i_q_s,
  input  logic [FRAC_BITS:0]    i_q_t,
  cmfs_out_if.source            out_ch
);

  localparam int W  = COMP_WIDTH;
  localparam int QW = FRAC_BITS + 1;
  localparam int XW = QW + COMP_WIDTH;

  logic [XW-1:0]               qx_s, qx_t, sv_s, sv_t;
  logic [W-1:0]                coord_s_nxt, coord_t_nxt;

  logic                        vld_r;
  logic [cmfs_pkg::FACE_W-1:0] face_r;
  logic [W-1:0]                coord_s_r, coord_t_r;
  logic                        zero_r;

  assign qx_s = XW'(i_q_s);
  assign qx_t = XW'(i_q_t);
  assign sv_s = i_side.neg_s ? (~qx_s + XW'(1)) : qx_s;
  assign sv_t = i_side.neg_t ? (~qx_t + XW'(1)) : qx_t;

  assign coord_s_nxt = i_side.zero ? '0 : sv_s[W-1:0];
  assign coord_t_nxt = i_side.zero ? '0 : sv_t[W-1:0];

  assign i_rdy = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (i_rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (i_vld && i_rdy) begin
      face_r    <= i_side.face;
      coord_s_r <= coord_s_nxt;
      coord_t_r <= coord_t_nxt;
      zero_r    <= i_side.zero;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.face_index  = face_r;
  assign out_ch.coord_s     = $signed(coord_s_r);
  assign out_ch.coord_t     = $signed(coord_t_r);
  assign out_ch.zero_vector = zero_r;

endmodule

>>> hdl/cube_map_face_select_unit.sv
`timescale 1ns / 1ps

// channel | dir | signals                                           | beat when
// --------+-----+---------------------------------------------------+-------------
// in_ch   | in  | valid ready dir_x dir_y dir_z                     | valid&ready
// out_ch  | out | valid ready face_index coord_s coord_t zero_vector | valid&ready
//
// One beat per cycle sustained while out_ch is not stalled. Stages in order:
// one select stage, FRAC_BITS+1 divider cells (one quotient bit each), one
// output register. The cell row makes up most of the stages.
// Synchronous active-low reset clears every stage valid.
// Each stage holds its beat on a stall and takes a new one as soon as the
// stage after it moves, so bubbles collapse.

module cube_map_face_select_unit #(
  parameter int COMP_WIDTH = cmfs_pkg::COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = cmfs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cmfs_in_if.sink     in_ch,
  cmfs_out_if.source  out_ch
);

  localparam int W  = COMP_WIDTH;
  localparam int NW = COMP_WIDTH + FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NC = FRAC_BITS + 1;

  logic            vld  [NC+1];
  logic            rdy  [NC+1];
  cmfs_pkg::side_t side [NC+1];
  logic [W-1:0]    den  [NC+1];
  logic [NW-1:0]   rem_s[NC+1];
  logic [NW-1:0]   rem_t[NC+1];
  logic [QW-1:0]   q_s  [NC+1];
  logic [QW-1:0]   q_t  [NC+1];

  cmfs_select #(
    .COMP_WIDTH(COMP_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .o_vld  (vld[0]),
    .o_rdy  (rdy[0]),
    .o_side (side[0]),
    .o_den  (den[0]),
    .o_rem_s(rem_s[0]),
    .o_rem_t(rem_t[0])
  );

  assign q_s[0] = '0;
  assign q_t[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cmfs_div_cell #(
      .COMP_WIDTH(COMP_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .SH        (FRAC_BITS - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .i_vld  (vld[k]),
      .i_rdy  (rdy[k]),
      .i_side (side[k]),
      .i_den  (den[k]),
      .i_rem_s(rem_s[k]),
      .i_rem_t(rem_t[k]),
      .i_q_s  (q_s[k]),
      .i_q_t  (q_t[k]),
      .o_vld  (vld[k+1]),
      .o_rdy  (rdy[k+1]),
      .o_side (side[k+1]),
      .o_den  (den[k+1]),
      .o_rem_s(rem_s[k+1]),
      .o_rem_t(rem_t[k+1]),
      .o_q_s  (q_s[k+1]),
      .o_q_t  (q_t[k+1])
    );
  end

  cmfs_out_stage #(
    .COMP_WIDTH(COMP_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .i_vld (vld[NC]),
    .i_rdy (rdy[NC]),
    .i_side(side[NC]),
    .i_q_s (q_s[NC]),
    .i_q_t (q_t[NC]),
    .out_ch(out_ch)
  );

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !vld[0])
    else $error("pipeline valid set after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted beat missing from select stage");

  a_zero_forced: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_vector |->
      out_ch.face_index == '0 && out_ch.coord_s == '0 && out_ch.coord_t == '0)
    else $error("zero vector beat carries nonzero face or coordinates");

  a_last_cell_held: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NC] && !rdy[NC] |=> vld[NC] && $stable(q_s[NC]) && $stable(q_t[NC]))
    else $error("last divider cell lost a stalled beat");

endmodule

>>> tb/tb_cube_map_face_select_unit.sv
`timescale 1ns / 1ps

module tb_cube_map_face_select_unit;

  localparam int CW          = cmfs_pkg::COMP_WIDTH_DEF;
  localparam int FB          = cmfs_pkg::FRAC_BITS_DEF;
  localparam int LATENCY     = FB + 3;
  localparam int RAND_DIRS   = 1200;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [cmfs_pkg::FACE_W-1:0] face;
    logic signed [CW-1:0]        s;
    logic signed [CW-1:0]        t;
    logic                        zero;
  } face_beat_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit                   typed;
    face_beat_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cmfs_in_if  #(.COMP_WIDTH(CW)) in_ch ();
  cmfs_out_if #(.COMP_WIDTH(CW)) out_ch ();

  cube_map_face_select_unit #(
    .COMP_WIDTH(CW),
    .FRAC_BITS (FB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  face_beat_t pending_faces[$];
  dir_row_t   dir_table[$];
  int         phase = 0;
  bit         long_hold_done = 1'b0;
  int         errors = 0;
  int         dirs_in = 0;
  int         faces_out = 0;
  int         zeros_out = 0;
  int         hold_cycles = 0;

  function automatic logic [CW-1:0] scaled_ratio(logic [CW:0] num, bit negate, logic [CW:0] den);
    logic [63:0] n;
    logic [63:0] q;
    n = 64'(num) << FB;
    q = (2 * n + 64'(den)) / (2 * 64'(den));
    if (negate) q = 64'd0 - q;
    return q[CW-1:0];
  endfunction

  function automatic face_beat_t face_of(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         logic signed [CW-1:0] z);
    logic signed [CW-1:0] comp[3];
    logic [CW:0]          mag[3];
    bit                   sgn[3];
    cmfs_pkg::axis_t      axis;
    int                   ib;
    int                   ic;
    face_beat_t           r;
    comp[0] = x;
    comp[1] = y;
    comp[2] = z;
    for (int i = 0; i < 3; i++) begin
      sgn[i] = comp[i][CW-1];
      mag[i] = sgn[i] ? ((CW+1)'(1) << CW) - {1'b0, comp[i]} : {1'b0, comp[i]};
    end
    r = '0;
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      r.zero = 1'b1;
      return r;
    end
    if (mag[0] >= mag[1] && mag[0] >= mag[2]) axis = cmfs_pkg::AXIS_X;
    else if (mag[1] >= mag[2]) axis = cmfs_pkg::AXIS_Y;
    else axis = cmfs_pkg::AXIS_Z;
    ib = (int'(axis) + 1) % 3;
    ic = (int'(axis) + 2) % 3;
    r.face = {axis, sgn[int'(axis)]};
    r.s    = scaled_ratio(mag[ib], sgn[ib], mag[int'(axis)]);
    r.t    = scaled_ratio(mag[ic], sgn[ic], mag[int'(axis)]);
    return r;
  endfunction

  function automatic void add_row(int x, int y, int z, bit typed,
                                  logic [cmfs_pkg::FACE_W-1:0] face, int s, int t, bit zero);
    dir_row_t row;
    row.x         = CW'(x);
    row.y         = CW'(y);
    row.z         = CW'(z);
    row.typed     = typed;
    row.want.face = face;
    row.want.s    = CW'(s);
    row.want.t    = CW'(t);
    row.want.zero = zero;
    dir_table.push_back(row);
  endfunction

  function automatic logic signed [CW-1:0] pick_comp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return {1'b1, {(CW-1){1'b0}}};
      2:       return {1'b0, {(CW-1){1'b1}}};
      3:       return CW'(int'($urandom_range(0, 31)) - 16);
      4:       return CW'(int'($urandom_range(0, 1023)) - 512);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic int sender_idle_pct();
    return (phase == 0) ? 27 : (phase == 1) ? 79 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (phase == 0) ? 79 : (phase == 1) ? 27 : 0;
  endfunction

  task automatic send_dir(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                          logic signed [CW-1:0] z, face_beat_t want);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dir_x <= x;
    in_ch.dir_y <= y;
    in_ch.dir_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_faces.push_back(want);
    dirs_in++;
  endtask

  initial begin
    forever begin
      if (phase == 2 && !long_hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
        long_hold_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    face_beat_t exp_face;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      faces_out++;
      if (out_ch.zero_vector === 1'b1) zeros_out++;
      if (pending_faces.size() == 0) begin
        $error("result beat with no direction pending");
        errors++;
      end else begin
        exp_face = pending_faces.pop_front();
        if (out_ch.face_index !== exp_face.face) begin
          $error("face_index: expected %0d, got %0d", exp_face.face, out_ch.face_index);
          errors++;
        end
        if (out_ch.coord_s !== exp_face.s) begin
          $error("coord_s: expected %0d, got %0d", exp_face.s, out_ch.coord_s);
          errors++;
        end
        if (out_ch.coord_t !== exp_face.t) begin
          $error("coord_t: expected %0d, got %0d", exp_face.t, out_ch.coord_t);
          errors++;
        end
        if (out_ch.zero_vector !== exp_face.zero) begin
          $error("zero_vector: expected %0d, got %0d", exp_face.zero, out_ch.zero_vector);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;
    int                   kind;
    face_beat_t           want;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.dir_x <= '0;
    in_ch.dir_y <= '0;
    in_ch.dir_z <= '0;

    add_row(0, 0, 0, 1, '0, 0, 0, 1);
    add_row(16384, 0, 0, 1, {cmfs_pkg::AXIS_X, 1'b0}, 0, 0, 0);
    add_row(-32768, 0, 0, 1, {cmfs_pkg::AXIS_X, 1'b1}, 0, 0, 0);
    add_row(-1, 0, 0, 1, {cmfs_pkg::AXIS_X, 1'b1}, 0, 0, 0);
    add_row(0, 32767, 0, 1, {cmfs_pkg::AXIS_Y, 1'b0}, 0, 0, 0);
    add_row(0, -32768, 0, 1, {cmfs_pkg::AXIS_Y, 1'b1}, 0, 0, 0);
    add_row(0, 0, 32767, 1, {cmfs_pkg::AXIS_Z, 1'b0}, 0, 0, 0);
    add_row(0, 0, 1, 1, {cmfs_pkg::AXIS_Z, 1'b0}, 0, 0, 0);
    add_row(0, 0, -32768, 1, {cmfs_pkg::AXIS_Z, 1'b1}, 0, 0, 0);
    add_row(32767, 32767, 32767, 1, {cmfs_pkg::AXIS_X, 1'b0}, 16384, 16384, 0);
    add_row(-32768, -32768, -32768, 1, {cmfs_pkg::AXIS_X, 1'b1}, -16384, -16384, 0);
    add_row(1, -1, -1, 1, {cmfs_pkg::AXIS_X, 1'b0}, -16384, -16384, 0);
    add_row(100, -100, 50, 1, {cmfs_pkg::AXIS_X, 1'b0}, -16384, 8192, 0);
    add_row(0, 200, -200, 1, {cmfs_pkg::AXIS_Y, 1'b0}, -16384, 0, 0);
    add_row(-7, 0, 7, 1, {cmfs_pkg::AXIS_X, 1'b1}, 0, 16384, 0);
    add_row(-32768, 1, -1, 1, {cmfs_pkg::AXIS_X, 1'b1}, 1, -1, 0);
    add_row(-32768, 0, -32768, 1, {cmfs_pkg::AXIS_X, 1'b1}, 0, -16384, 0);
    add_row(32767, -32768, 0, 0, '0, 0, 0, 0);
    add_row(3, 1, -2, 0, '0, 0, 0, 0);
    add_row(-32767, 32767, -32768, 0, '0, 0, 0, 0);
    add_row(12345, -23456, 30000, 0, '0, 0, 0, 0);
    add_row(-3, 2, 1, 0, '0, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      want = dir_table[i].typed ? dir_table[i].want
                                : face_of(dir_table[i].x, dir_table[i].y, dir_table[i].z);
      send_dir(dir_table[i].x, dir_table[i].y, dir_table[i].z, want);
    end

    for (int i = 0; i < RAND_DIRS; i++) begin
      phase = (i < RAND_DIRS / 3) ? 0 : (i < 2 * RAND_DIRS / 3) ? 1 : 2;
      rx   = pick_comp();
      ry   = pick_comp();
      rz   = pick_comp();
      kind = $urandom_range(0, 19);
      case (kind)
        0:       begin rx = '0; ry = '0; rz = '0; end
        1, 2:    ry = $urandom_range(0, 1) ? rx : -rx;
        3, 4:    rz = $urandom_range(0, 1) ? ry : -ry;
        5:       rz = $urandom_range(0, 1) ? rx : -rx;
        6:       begin ry = rx; rz = -rx; end
        default: ;
      endcase
      send_dir(rx, ry, rz, face_of(rx, ry, rz));
    end
    in_ch.valid <= 1'b0;

    while (pending_faces.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("%0d directions in, %0d faces out, %0d of them zero vectors", dirs_in, faces_out,
             zeros_out);
    $display("idle mixes on both sides, plus one %0d-cycle output hold-off", hold_cycles);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
